// File: hw/rtl/msq_pkg.sv
`default_nettype none
package msq_pkg;

  localparam int NUM_SLOTS   = 16;
  localparam int PERIOD_BITS = 24;
  localparam int MAX_RESULTS = 16;

  localparam int SLOT_W   = 4;
  localparam int PERIOD_W = 24;
  localparam int TIME_W   = 32;

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W = $clog2(MAX_RESULTS + 1);

  localparam logic CMD_ARM  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    logic arm;
    logic start;
    logic take;
    logic advance;
    logic emit_last;
  } msq_cmd_t;

  typedef struct packed {
    logic due;
    logic at_end;
    logic pend_valid;
    logic out_free;
  } msq_stat_t;

endpackage
`default_nettype wire

// File: hw/rtl/msq_if.sv
`default_nettype none
interface msq_req_if;
  import msq_pkg::*;
  logic                valid;
  logic                ready;
  logic                command;
  logic [SLOT_W-1:0]   slot;
  logic                periodic;
  logic [PERIOD_W-1:0] period_ms;
  modport source (output valid, command, slot, periodic, period_ms, input ready);
  modport sink (input valid, command, slot, periodic, period_ms, output ready);
endinterface

interface msq_rsp_if;
  import msq_pkg::*;
  logic              valid;
  logic              ready;
  logic [SLOT_W-1:0] expired_slot;
  logic              last;
  modport source (output valid, expired_slot, last, input ready);
  modport sink (input valid, expired_slot, last, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/msq_datapath.sv
`default_nettype none
module msq_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  msq_pkg::msq_cmd_t                   cmd,
  output msq_pkg::msq_stat_t                  stat,
  input  logic [msq_pkg::SLOT_W-1:0]          arm_slot,
  input  logic                                arm_periodic,
  input  logic [msq_pkg::PERIOD_W-1:0]        arm_period,
  output logic                                rsp_valid,
  input  logic                                rsp_ready,
  output logic [msq_pkg::SLOT_W-1:0]          rsp_slot,
  output logic                                rsp_last
);
  import msq_pkg::*;

  logic [TIME_W-1:0]      now;
  idx_t                   idx;
  idx_t                   idx_next;
  idx_t                   rd_addr;
  logic [CNT_W-1:0]       found;
  logic [NUM_SLOTS-1:0]   armed;
  logic                   pend_valid;
  idx_t                   pend_idx;

  logic [TIME_W-1:0]      deadline_mem [NUM_SLOTS];
  logic [PERIOD_BITS:0]   mode_mem [NUM_SLOTS];
  logic [TIME_W-1:0]      rd_deadline;
  logic [PERIOD_BITS:0]   rd_mode;

  logic                   arm_hit;
  idx_t                   arm_idx;
  logic [PERIOD_BITS-1:0] arm_len;
  logic [TIME_W-1:0]      diff;
  logic                   past;
  logic                   rearm;
  logic                   wr_en;
  idx_t                   wr_addr;
  logic [TIME_W-1:0]      wr_data;
  logic                   load_out;

  always_comb begin
    arm_idx  = IDX_W'(arm_slot);
    arm_len  = PERIOD_BITS'(arm_period);
    arm_hit  = cmd.arm && (32'(arm_slot) < 32'(NUM_SLOTS));
    idx_next = cmd.advance ? idx + IDX_W'(1) : idx;
    rd_addr  = cmd.start ? '0 : idx_next;
    diff     = now - rd_deadline;
    past     = (diff != '0) && !diff[TIME_W-1];
    rearm    = cmd.take && rd_mode[PERIOD_BITS];
    load_out = (cmd.take && pend_valid) || cmd.emit_last;

    stat.due        = armed[idx] && past && (32'(found) < 32'(MAX_RESULTS));
    stat.at_end     = (idx == IDX_W'(NUM_SLOTS - 1));
    stat.pend_valid = pend_valid;
    stat.out_free   = !rsp_valid || rsp_ready;

    wr_en   = arm_hit || rearm;
    wr_addr = arm_hit ? arm_idx : idx;
    wr_data = arm_hit ? now + TIME_W'(arm_len)
                      : now + TIME_W'(rd_mode[PERIOD_BITS-1:0]);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      deadline_mem[wr_addr] <= wr_data;
    end
    if (arm_hit) begin
      mode_mem[arm_idx] <= {arm_periodic, arm_len};
    end
    rd_deadline <= deadline_mem[rd_addr];
    rd_mode     <= mode_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      now        <= '0;
      idx        <= '0;
      found      <= '0;
      armed      <= '0;
      pend_valid <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      if (cmd.start) begin
        now   <= now + TIME_W'(1);
        idx   <= '0;
        found <= '0;
      end else begin
        idx <= idx_next;
      end
      if (arm_hit) begin
        armed[arm_idx] <= 1'b1;
      end
      if (cmd.take) begin
        found <= found + CNT_W'(1);
        if (!rd_mode[PERIOD_BITS]) begin
          armed[idx] <= 1'b0;
        end
      end
      if (cmd.take) begin
        pend_valid <= 1'b1;
      end else if (cmd.emit_last) begin
        pend_valid <= 1'b0;
      end
      if (load_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      pend_idx <= idx;
    end
    if (load_out) begin
      rsp_slot <= SLOT_W'(pend_idx);
      rsp_last <= cmd.emit_last;
    end
  end

`ifndef ASSERT_OFF
  a_take_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.take |-> (!pend_valid || !rsp_valid || rsp_ready))
    else $error("expiry overwrites an unconsumed result");

  a_last_needs_pending: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_last |-> pend_valid)
    else $error("final expiry released with nothing pending");

  a_start_clean: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> (idx == '0) && (found == '0) && !pend_valid)
    else $error("scan starts with stale state");
`endif

endmodule
`default_nettype wire

// File: hw/rtl/msq_ctrl.sv
`default_nettype none
module msq_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  input  logic                req_tick,
  output logic                req_ready,
  input  msq_pkg::msq_stat_t  stat,
  output msq_pkg::msq_cmd_t   cmd
);
  import msq_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_FLUSH = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    req_ready  = (state == ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          if (req_tick) begin
            cmd.start  = 1'b1;
            state_next = ST_SCAN;
          end else begin
            cmd.arm = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        if (stat.due) begin
          if (!stat.pend_valid || stat.out_free) begin
            cmd.take    = 1'b1;
            cmd.advance = 1'b1;
          end
        end else begin
          cmd.advance = 1'b1;
        end
        if (cmd.advance && stat.at_end) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!stat.pend_valid) begin
          state_next = ST_IDLE;
        end else if (stat.out_free) begin
          cmd.emit_last = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef ASSERT_OFF
  a_flush_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FLUSH) && !stat.pend_valid |=> (state == ST_IDLE))
    else $error("flush does not return to idle");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) && stat.due && stat.pend_valid && !stat.out_free
      |-> !cmd.advance && !cmd.take)
    else $error("scan advances past a blocked expiry");

  a_tick_starts_scan: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> (state == ST_SCAN))
    else $error("tick request does not start a scan");
`endif

endmodule
`default_nettype wire

// File: hw/rtl/multi_slot_timer_queue.sv
`default_nettype none
// Arm request: accepted while idle, no result.
// Tick request: a setup step, then one slot per cycle through the slot memory read port
// unless a blocked expiry stalls the scan, then a final release step.
// An expiry leaves once the next due slot or the end of the scan is found.
// Reset (synchronous, active high) clears the clock, armed bits and output valid;
// slot memories are not cleared.
module multi_slot_timer_queue (
  input  logic      clk,
  input  logic      rst,
  msq_req_if.sink   req,
  msq_rsp_if.source rsp
);
  import msq_pkg::*;

  msq_cmd_t  cmd;
  msq_stat_t stat;
  logic      req_tick;

  assign req_tick = (req.command == CMD_TICK);

  msq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_tick  (req_tick),
    .req_ready (req.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  msq_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .arm_slot     (req.slot),
    .arm_periodic (req.periodic),
    .arm_period   (req.period_ms),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .rsp_slot     (rsp.expired_slot),
    .rsp_last     (rsp.last)
  );

endmodule
`default_nettype wire
